>>> design/wpi_pkg.sv
`default_nettype none
package wpi_pkg;

   localparam logic [1:0] CSR_LOOP_ENABLE    = 2'd0;
   localparam logic [1:0] CSR_WAYPOINT_COUNT = 2'd1;
   localparam logic [1:0] CSR_MIN_INTERVAL   = 2'd2;

   localparam logic ACT_TICK = 1'b0;
   localparam logic ACT_LOAD = 1'b1;

   typedef struct packed {
      logic               action;
      logic [3:0]         entry_index;
      logic [31:0]        time_value;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
      logic signed [15:0] yaw_angle;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [15:0] out_roll;
      logic signed [15:0] out_pitch;
      logic signed [15:0] out_yaw;
   } rsp_type;

   typedef struct packed {
      logic [31:0] tm;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [15:0] roll;
      logic [15:0] pitch;
      logic [15:0] yaw;
   } entry_type;

   typedef struct packed {
      logic accept_tick;
      logic load;
      logic ld_cur;
      logic ld_prev;
      logic ld_t_now;
      logic ld_t_rem;
      logic div_mod;
      logic div_ratio;
      logic ld_r;
      logic clr_r;
      logic mul;
      logic add;
   } cmd_type;

   typedef struct packed {
      logic is_load;
      logic tick_pass;
      logic n_one;
      logic loop_on;
      logic now_ge_end;
      logic t_le;
      logic div_done;
   } stat_type;

endpackage
`default_nettype wire

>>> design/wpi_ram.sv
`default_nettype none
module wpi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

>>> design/wpi_div.sv
`default_nettype none
module wpi_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [47:0] dividend,
   input  wire logic [31:0] divisor,
   input  wire logic [5:0]  steps,
   output logic             done,
   output logic [16:0]      quotient,
   output logic [31:0]      remainder
);
   logic        run_ff, done_ff;
   logic [5:0]  cnt_ff;
   logic [47:0] num_ff;
   logic [31:0] rem_ff, dvs_ff;
   logic [16:0] q_ff;
   logic [32:0] trial;
   logic        ge;

   assign trial = {rem_ff, num_ff[47]};
   assign ge    = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
            cnt_ff <= steps;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff - 6'd1;
            if (cnt_ff == 6'd1) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         num_ff <= dividend;
         dvs_ff <= divisor;
         rem_ff <= '0;
         q_ff   <= '0;
      end else if (run_ff) begin
         num_ff <= {num_ff[46:0], 1'b0};
         rem_ff <= ge ? 32'(trial - {1'b0, dvs_ff}) : trial[31:0];
         q_ff   <= {q_ff[15:0], ge};
      end
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = rem_ff;
endmodule
`default_nettype wire

>>> design/wpi_datapath.sv
`default_nettype none
module wpi_datapath #(
   parameter int MAX_WAYPOINTS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [1:0]                       csr_index,
   input  wire logic [15:0]                      csr_wdata,
   input  wire wpi_pkg::req_type                 req_data,
   input  wire wpi_pkg::cmd_type                 cmd,
   input  wire logic [$clog2(MAX_WAYPOINTS)-1:0] rd_addr,
   output wpi_pkg::stat_type                     stat,
   output logic [$clog2(MAX_WAYPOINTS)-1:0]      last_idx,
   output wpi_pkg::rsp_type                      rsp_data
);
   localparam int AW = $clog2(MAX_WAYPOINTS);

   logic              loop_ff;
   logic [4:0]        count_ff;
   logic [15:0]       min_ff;
   logic [31:0]       last_emit_ff, now_ff, t_ff, span_tm;
   logic [16:0]       r_ff;
   wpi_pkg::entry_type rd, prev_ff, cur_ff, wr;
   logic              div_start, div_done;
   logic [47:0]       div_num;
   logic [31:0]       div_dvs;
   logic [16:0]       div_q;
   logic [31:0]       div_rem;
   logic signed [32:0] gap, dd, ee;
   logic [31:0]       n_ext;
   logic signed [50:0] px_ff, py_ff, pz_ff;
   logic signed [34:0] pa_ff [3];
   logic signed [50:0] sx, sy, sz;
   logic signed [34:0] sa [3];
   logic [15:0]       ang_a [3], ang_b [3];
   logic signed [17:0] fold [3];
   wpi_pkg::rsp_type  out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_ff      <= 1'b1;
         count_ff     <= 5'd1;
         min_ff       <= 16'd33;
         last_emit_ff <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               wpi_pkg::CSR_LOOP_ENABLE:    loop_ff  <= csr_wdata[0];
               wpi_pkg::CSR_WAYPOINT_COUNT: count_ff <= csr_wdata[4:0];
               wpi_pkg::CSR_MIN_INTERVAL:   min_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.accept_tick) begin
            last_emit_ff <= req_data.time_value;
         end
      end
   end

   // throttle and count clamp
   assign gap = $signed({1'b0, req_data.time_value}) - $signed({1'b0, last_emit_ff});
   always_comb begin
      n_ext = 32'(count_ff);
      if (n_ext == 32'd0) n_ext = 32'd1;
      if (n_ext > 32'(MAX_WAYPOINTS)) n_ext = 32'(MAX_WAYPOINTS);
   end
   assign last_idx = AW'(n_ext - 32'd1);

   assign span_tm = (rd.tm == 32'd0) ? 32'd1 : rd.tm;

   assign stat.is_load    = (req_data.action == wpi_pkg::ACT_LOAD);
   assign stat.tick_pass  = (min_ff == 16'd0) || !(gap < $signed({17'd0, min_ff}));
   assign stat.n_one      = (n_ext == 32'd1);
   assign stat.loop_on    = loop_ff;
   assign stat.now_ge_end = now_ff >= span_tm;
   assign stat.t_le       = t_ff <= rd.tm;
   assign stat.div_done   = div_done;

   // table
   assign wr = '{tm: req_data.time_value, x: req_data.pos_x, y: req_data.pos_y,
                 z: req_data.pos_z, roll: req_data.roll_angle,
                 pitch: req_data.pitch_angle, yaw: req_data.yaw_angle};

   wpi_ram #(.WIDTH($bits(wpi_pkg::entry_type)), .DEPTH(MAX_WAYPOINTS)) u_table (
      .clock (clock),
      .we    (cmd.load && (32'(req_data.entry_index) < 32'(MAX_WAYPOINTS))),
      .waddr (AW'(req_data.entry_index)),
      .wdata (wr),
      .raddr (rd_addr),
      .rdata (rd)
   );

   // segment ratio operands
   always_comb begin
      dd = $signed({1'b0, cur_ff.tm}) - $signed({1'b0, prev_ff.tm});
      if (dd < 33'sd1) dd = 33'sd1;
      ee = $signed({1'b0, t_ff}) - $signed({1'b0, prev_ff.tm});
      if (ee < 33'sd0) ee = 33'sd0;
      if (ee > dd) ee = dd;
   end

   assign div_start = cmd.div_mod || cmd.div_ratio;
   assign div_num   = cmd.div_mod ? {now_ff, 16'd0} : {ee[31:0], 16'd0};
   assign div_dvs   = cmd.div_mod ? span_tm : dd[31:0];

   wpi_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_num),
      .divisor   (div_dvs),
      .steps     (cmd.div_mod ? 6'd32 : 6'd48),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_rem)
   );

   // shortest-way angle deltas
   always_comb begin
      ang_a[0] = prev_ff.roll;  ang_b[0] = cur_ff.roll;
      ang_a[1] = prev_ff.pitch; ang_b[1] = cur_ff.pitch;
      ang_a[2] = prev_ff.yaw;   ang_b[2] = cur_ff.yaw;
      for (int k = 0; k < 3; k++) begin
         fold[k] = $signed({{2{ang_b[k][15]}}, ang_b[k]})
                 - $signed({{2{ang_a[k][15]}}, ang_a[k]});
         if (fold[k] > 18'sd32768) fold[k] = fold[k] - 18'sd65536;
         else if (fold[k] < -18'sd32768) fold[k] = fold[k] + 18'sd65536;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept_tick) now_ff <= req_data.time_value;
      if (cmd.ld_cur)      cur_ff <= rd;
      if (cmd.ld_prev)     prev_ff <= rd;
      if (cmd.ld_t_now)    t_ff <= now_ff;
      else if (cmd.ld_t_rem) t_ff <= div_rem;
      if (cmd.ld_r)        r_ff <= div_q;
      else if (cmd.clr_r)  r_ff <= '0;
      if (cmd.mul) begin
         px_ff <= ($signed({cur_ff.x[31], cur_ff.x}) - $signed({prev_ff.x[31], prev_ff.x}))
                * $signed({1'b0, r_ff});
         py_ff <= ($signed({cur_ff.y[31], cur_ff.y}) - $signed({prev_ff.y[31], prev_ff.y}))
                * $signed({1'b0, r_ff});
         pz_ff <= ($signed({cur_ff.z[31], cur_ff.z}) - $signed({prev_ff.z[31], prev_ff.z}))
                * $signed({1'b0, r_ff});
         for (int k = 0; k < 3; k++) begin
            pa_ff[k] <= 35'(fold[k] * $signed({1'b0, r_ff}));
         end
      end
      if (cmd.add) begin
         out_ff.out_x     <= prev_ff.x + sx[31:0];
         out_ff.out_y     <= prev_ff.y + sy[31:0];
         out_ff.out_z     <= prev_ff.z + sz[31:0];
         out_ff.out_roll  <= prev_ff.roll + sa[0][15:0];
         out_ff.out_pitch <= prev_ff.pitch + sa[1][15:0];
         out_ff.out_yaw   <= prev_ff.yaw + sa[2][15:0];
      end
   end

   always_comb begin
      sx = px_ff >>> 16;
      sy = py_ff >>> 16;
      sz = pz_ff >>> 16;
      for (int k = 0; k < 3; k++) begin
         sa[k] = pa_ff[k] >>> 16;
      end
   end

   assign rsp_data = out_ff;
endmodule
`default_nettype wire

>>> design/wpi_ctrl.sv
`default_nettype none
module wpi_ctrl #(
   parameter int MAX_WAYPOINTS = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire wpi_pkg::stat_type                stat,
   input  wire logic [$clog2(MAX_WAYPOINTS)-1:0] last_idx,
   output wpi_pkg::cmd_type                      cmd,
   output logic [$clog2(MAX_WAYPOINTS)-1:0]      rd_addr,
   output logic                                  busy,
   output logic                                  rsp_valid
);
   localparam int AW = $clog2(MAX_WAYPOINTS);

   typedef enum logic [3:0] {
      ST_IDLE, ST_END, ST_MOD, ST_SRCH0, ST_SRCH, ST_SETUP, ST_RATIO, ST_ONE,
      ST_MUL, ST_ADD
   } state_type;

   state_type      state_ff, state_in;
   logic [AW-1:0]  i_ff, i_in;
   logic           valid_ff;

   always_comb begin
      cmd      = '0;
      rd_addr  = '0;
      state_in = state_ff;
      i_in     = i_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (stat.is_load) begin
                  cmd.load = 1'b1;
               end else if (stat.tick_pass) begin
                  cmd.accept_tick = 1'b1;
                  rd_addr  = stat.n_one ? '0 : last_idx;
                  state_in = stat.n_one ? ST_ONE : ST_END;
               end
            end
         end
         ST_END: begin
            cmd.ld_cur = 1'b1;
            if (stat.loop_on) begin
               cmd.div_mod = 1'b1;
               state_in    = ST_MOD;
            end else if (stat.now_ge_end) begin
               cmd.ld_prev = 1'b1;
               cmd.clr_r   = 1'b1;
               state_in    = ST_MUL;
            end else begin
               cmd.ld_t_now = 1'b1;
               state_in     = ST_SRCH0;
            end
         end
         ST_MOD: begin
            if (stat.div_done) begin
               cmd.ld_t_rem = 1'b1;
               state_in     = ST_SRCH0;
            end
         end
         ST_SRCH0: begin
            cmd.ld_prev = 1'b1;
            i_in        = AW'(1);
            rd_addr     = AW'(1);
            state_in    = ST_SRCH;
         end
         ST_SRCH: begin
            if (stat.t_le) begin
               cmd.ld_cur = 1'b1;
               state_in   = ST_SETUP;
            end else if (i_ff == last_idx) begin
               cmd.ld_prev = 1'b1;
               cmd.clr_r   = 1'b1;
               state_in    = ST_MUL;
            end else begin
               cmd.ld_prev = 1'b1;
               i_in        = i_ff + AW'(1);
               rd_addr     = i_ff + AW'(1);
            end
         end
         ST_SETUP: begin
            cmd.div_ratio = 1'b1;
            state_in      = ST_RATIO;
         end
         ST_RATIO: begin
            if (stat.div_done) begin
               cmd.ld_r = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_ONE: begin
            cmd.ld_prev = 1'b1;
            cmd.ld_cur  = 1'b1;
            cmd.clr_r   = 1'b1;
            state_in    = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            cmd.add  = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         valid_ff <= (state_ff == ST_ADD);
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
endmodule
`default_nettype wire

>>> design/waypoint_pose_interpolator.sv
// channel  direction  handshake                 beat
// req      in         start high, busy low      wpi_pkg::req_type
// rsp      out        rsp_valid, one cycle      wpi_pkg::rsp_type
// csr      in         csr_we                    index csr_index, data csr_wdata
//
// a load beat or a dropped tick leaves busy low; an emitted tick holds busy until the
// result: one entry or a held final pose goes straight to the multiply and add, else
// a segment search runs, with a ratio divide if one fits, after a modulo divide when
// looping; the shared bit-serial divider sets most of it; rsp_valid rises as busy falls
// reset is synchronous; it clears the control state and the CSRs to their defaults
// the receiver cannot stall: rsp_valid is high for one cycle per result
`default_nettype none
module waypoint_pose_interpolator #(
   parameter int MAX_WAYPOINTS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire wpi_pkg::req_type req_data,
   output logic                  rsp_valid,
   output wpi_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [15:0]      csr_wdata
);
   localparam int AW = $clog2(MAX_WAYPOINTS);

   wpi_pkg::cmd_type  cmd;
   wpi_pkg::stat_type stat;
   logic [AW-1:0]     rd_addr, last_idx;

   wpi_ctrl #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (stat),
      .last_idx  (last_idx),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   wpi_datapath #(.MAX_WAYPOINTS(MAX_WAYPOINTS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .rd_addr   (rd_addr),
      .stat      (stat),
      .last_idx  (last_idx),
      .rsp_data  (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   assert property (@(posedge clock) disable iff (reset)
                    (start && !busy && req_data.action == wpi_pkg::ACT_LOAD) |=> !busy)
      else $error("load beat left the block busy");

   assert property (@(posedge clock) $past(reset) |-> (!busy && !rsp_valid))
      else $error("block not idle after reset");
endmodule
`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;

   localparam int LIMIT = 3000000;
   localparam int SETTLE = 160;

   typedef enum logic [1:0] {OP_BEAT, OP_CSR, OP_DRAIN} op_kind_type;
   typedef struct {
      op_kind_type      kind;
      wpi_pkg::req_type beat;
      logic [1:0]       idx;
      logic [15:0]      wdata;
   } op_type;

   logic             clock = 0;
   logic             reset = 1;
   logic             start = 0;
   logic             busy;
   wpi_pkg::req_type req_data = '0;
   logic             rsp_valid;
   wpi_pkg::rsp_type rsp_data;
   logic             csr_we = 0;
   logic [1:0]       csr_index = '0;
   logic [15:0]      csr_wdata = '0;

   waypoint_pose_interpolator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // shadow of the waypoint table and settings
   wpi_pkg::entry_type waypoints [16];
   logic        loop_on = 1;
   logic [4:0]  count_reg = 5'd1;
   logic [15:0] min_gap = 16'd33;
   logic [31:0] last_emit = '0;

   op_type           pending [$];
   wpi_pkg::rsp_type pose_due [$];
   int          errors = 0;
   int          cycles = 0;
   int          beats = 0;
   logic        took = 0;
   int          gap_left = 0;
   logic        draining = 0;
   int          settle_left = 0;
   logic [31:0] gen_time;

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
   end

   function automatic wpi_pkg::rsp_type pose_of(int k);
      wpi_pkg::rsp_type p;
      p.out_x = waypoints[k].x;
      p.out_y = waypoints[k].y;
      p.out_z = waypoints[k].z;
      p.out_roll = waypoints[k].roll;
      p.out_pitch = waypoints[k].pitch;
      p.out_yaw = waypoints[k].yaw;
      return p;
   endfunction

   function automatic logic [31:0] blend_pos(logic [31:0] a, logic [31:0] b, longint r);
      longint sa, v;
      sa = longint'($signed(a));
      v = sa + (((longint'($signed(b)) - sa) * r) >>> 16);
      return v[31:0];
   endfunction

   function automatic logic [15:0] blend_ang(logic [15:0] a, logic [15:0] b, longint r);
      longint sa, d, v;
      sa = longint'($signed(a));
      d = longint'($signed(b)) - sa;
      if (d > 32768) d -= 65536;
      else if (d < -32768) d += 65536;
      v = sa + ((d * r) >>> 16);
      return v[15:0];
   endfunction

   function automatic wpi_pkg::rsp_type blend(int i0, int i1, logic [31:0] t);
      wpi_pkg::rsp_type p;
      longint d, e, r;
      d = longint'(waypoints[i1].tm) - longint'(waypoints[i0].tm);
      e = longint'(t) - longint'(waypoints[i0].tm);
      if (d < 1) d = 1;
      if (e < 0) e = 0;
      if (e > d) e = d;
      r = (e << 16) / d;
      p.out_x = blend_pos(waypoints[i0].x, waypoints[i1].x, r);
      p.out_y = blend_pos(waypoints[i0].y, waypoints[i1].y, r);
      p.out_z = blend_pos(waypoints[i0].z, waypoints[i1].z, r);
      p.out_roll = blend_ang(waypoints[i0].roll, waypoints[i1].roll, r);
      p.out_pitch = blend_ang(waypoints[i0].pitch, waypoints[i1].pitch, r);
      p.out_yaw = blend_ang(waypoints[i0].yaw, waypoints[i1].yaw, r);
      return p;
   endfunction

   task automatic take_beat(wpi_pkg::req_type b);
      int n;
      logic [31:0] span, t;
      logic hit;
      if (b.action == wpi_pkg::ACT_LOAD) begin
         waypoints[b.entry_index] = '{b.time_value, b.pos_x, b.pos_y, b.pos_z,
                                      b.roll_angle, b.pitch_angle, b.yaw_angle};
         return;
      end
      if (min_gap != 0 && longint'(b.time_value) - longint'(last_emit) < longint'(min_gap))
         return;
      last_emit = b.time_value;
      n = (count_reg == 0) ? 1 : (count_reg > 16) ? 16 : count_reg;
      if (n == 1) begin
         pose_due.insert(pose_due.size(), pose_of(0));
         return;
      end
      span = (waypoints[n-1].tm < 1) ? 32'd1 : waypoints[n-1].tm;
      t = b.time_value;
      if (loop_on) t = t % span;
      else if (t >= span) begin
         pose_due.insert(pose_due.size(), pose_of(n - 1));
         return;
      end
      hit = 0;
      for (int i = 1; i < n && !hit; i++) begin
         if (t <= waypoints[i].tm) begin
            pose_due.insert(pose_due.size(), blend(i - 1, i, t));
            hit = 1;
         end
      end
      if (!hit) pose_due.insert(pose_due.size(), pose_of(n - 1));
   endtask

   task automatic check_field(string name, longint want, longint got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      wpi_pkg::rsp_type want;
      cycles++;
      if (cycles > LIMIT) begin
         $display("FAIL");
         $finish;
      end
      if (reset) begin
         took = 0;
      end else begin
         if (rsp_valid) begin
            if (pose_due.size() == 0) begin
               $error("unexpected pose beat");
               errors++;
            end else begin
               want = pose_due.pop_front();
               check_field("out_x", want.out_x, rsp_data.out_x);
               check_field("out_y", want.out_y, rsp_data.out_y);
               check_field("out_z", want.out_z, rsp_data.out_z);
               check_field("out_roll", want.out_roll, rsp_data.out_roll);
               check_field("out_pitch", want.out_pitch, rsp_data.out_pitch);
               check_field("out_yaw", want.out_yaw, rsp_data.out_yaw);
            end
         end
         took = start && !busy;
         if (took) take_beat(req_data);
         if (csr_we) begin
            case (csr_index)
               wpi_pkg::CSR_LOOP_ENABLE:    loop_on = csr_wdata[0];
               wpi_pkg::CSR_WAYPOINT_COUNT: count_reg = csr_wdata[4:0];
               wpi_pkg::CSR_MIN_INTERVAL:   min_gap = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always @(negedge clock) begin : drive
      logic nstart, nwe;
      op_type op;
      nstart = start && !took;
      nwe = 0;
      if (!reset && !nstart) begin
         if (gap_left != 0) begin
            gap_left--;
         end else if (draining) begin
            if (pose_due.size() == 0 && !busy) begin
               if (settle_left == 0) draining = 0;
               else settle_left--;
            end
         end else if (pending.size() != 0) begin
            if (pending.size() > 150 && $urandom_range(0, 3) == 0) begin
               gap_left = $urandom_range(0, 4);
            end else begin
               op = pending.pop_front();
               case (op.kind)
                  OP_BEAT: begin
                     nstart = 1;
                     req_data <= op.beat;
                  end
                  OP_CSR: begin
                     nwe = 1;
                     csr_index <= op.idx;
                     csr_wdata <= op.wdata;
                  end
                  default: begin
                     draining = 1;
                     settle_left = SETTLE;
                  end
               endcase
            end
         end
      end
      start <= nstart;
      csr_we <= nwe;
   end

   function automatic wpi_pkg::req_type make_load(logic [3:0] k, logic [31:0] t);
      wpi_pkg::req_type b;
      b = $bits(wpi_pkg::req_type)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom});
      b.action = wpi_pkg::ACT_LOAD;
      b.entry_index = k;
      b.time_value = t;
      return b;
   endfunction

   function automatic wpi_pkg::req_type make_tick(logic [31:0] t);
      wpi_pkg::req_type b;
      b = $bits(wpi_pkg::req_type)'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom});
      b.action = wpi_pkg::ACT_TICK;
      b.time_value = t;
      return b;
   endfunction

   task automatic push_beat(wpi_pkg::req_type b);
      pending.insert(pending.size(), '{OP_BEAT, b, 2'd0, 16'd0});
      beats++;
   endtask

   task automatic push_csr(logic [1:0] idx, logic [15:0] v);
      pending.insert(pending.size(), '{OP_CSR, '0, idx, v});
   endtask

   task automatic push_drain();
      pending.insert(pending.size(), '{OP_DRAIN, '0, 2'd0, 16'd0});
   endtask

   initial begin
      wpi_pkg::req_type b;
      int n, cnt, mi, ticks;
      logic [31:0] t;
      logic jumbled;

      // single entry, early first tick dropped
      push_beat(make_load(4'd0, 32'd100));
      push_beat(make_tick(32'd10));
      push_beat(make_tick(32'd40));
      push_drain();
      push_csr(wpi_pkg::CSR_WAYPOINT_COUNT, 16'd16);
      push_csr(wpi_pkg::CSR_MIN_INTERVAL, 16'd0);
      for (int k = 0; k < 16; k++) begin
         b = make_load(k[3:0], 32'(k * 1000));
         b.pos_x = k[0] ? 32'h7fffffff : 32'h80000000;
         b.roll_angle = k[0] ? 16'h7fff : 16'h8000;
         push_beat(b);
      end
      push_beat(make_tick(32'd0));
      push_beat(make_tick(32'd500));
      push_beat(make_tick(32'd15000));
      push_beat(make_tick(32'd15001));
      push_beat(make_tick(32'hffffffff));
      push_drain();
      push_csr(wpi_pkg::CSR_LOOP_ENABLE, 16'd0);
      push_beat(make_tick(32'd14999));
      push_beat(make_tick(32'd99999));
      push_beat(make_tick(32'd7500));
      push_drain();
      push_csr(wpi_pkg::CSR_MIN_INTERVAL, 16'hffff);
      push_beat(make_tick(32'd7000));
      push_beat(make_tick(32'd80000));
      gen_time = 32'd200000;

      while (beats < 1800) begin
         push_drain();
         push_csr(wpi_pkg::CSR_LOOP_ENABLE, 16'($urandom_range(0, 1)));
         case ($urandom_range(0, 9))
            0: cnt = 0;
            1: cnt = 1;
            2: cnt = 16;
            3: cnt = $urandom_range(17, 31);
            default: cnt = $urandom_range(2, 6);
         endcase
         push_csr(wpi_pkg::CSR_WAYPOINT_COUNT, 16'(cnt));
         case ($urandom_range(0, 9))
            0, 1, 2, 3: mi = 0;
            4: mi = 65535;
            5: mi = $urandom_range(1, 65534);
            default: mi = $urandom_range(1, 100);
         endcase
         push_csr(wpi_pkg::CSR_MIN_INTERVAL, 16'(mi));
         n = (cnt == 0) ? 1 : (cnt > 16) ? 16 : cnt;
         t = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 200);
         jumbled = ($urandom_range(0, 7) == 0);
         for (int k = 0; k < n; k++) begin
            push_beat(make_load(k[3:0], t));
            t = jumbled ? $urandom_range(0, 2000) : t + $urandom_range(0, 400);
         end
         ticks = $urandom_range(8, 30);
         for (int j = 0; j < ticks; j++) begin
            if (mi == 0) begin
               push_beat(make_tick($urandom_range(0, 3) == 0 ? $urandom
                                   : $urandom_range(0, t + 200)));
            end else begin
               if ($urandom_range(0, 15) == 0) gen_time -= $urandom_range(0, 100);
               else gen_time += $urandom_range(mi / 2, mi * 2);
               push_beat(make_tick(gen_time));
            end
         end
      end

      wait (!reset);
      while (pending.size() != 0 || start || draining || pose_due.size() != 0 || busy)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (pose_due.size() != 0) begin
         $error("%0d poses never arrived", pose_due.size());
         errors++;
      end
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
`default_nettype wire

>>> files.f
design/wpi_pkg.sv
design/wpi_ram.sv
design/wpi_div.sv
design/wpi_datapath.sv
design/wpi_ctrl.sv
design/waypoint_pose_interpolator.sv
tb/sv/tb.sv
